### rtl/ptd_pkg.sv
`default_nettype none
package ptd_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int unsigned OP_SET_TASK   = 2'd0;
  localparam int unsigned OP_START      = 2'd1;
  localparam int unsigned OP_TASK_DONE  = 2'd2;
  localparam int unsigned OP_RUN_NOW    = 2'd3;
  localparam logic [1:0] KIND_DISPATCH   = 2'd0;
  localparam logic [1:0] KIND_CYCLE_DONE = 2'd1;
  localparam logic [1:0] KIND_STANDALONE = 2'd2;
  localparam logic [31:0] BUDGET_RESET = 32'd1000;
  localparam logic [13:0] USAGE_SCALE  = 14'd10000;
  // divide by 5: reciprocal (2^34 + 1) / 5 and (2^32 - 1) / 5
  localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
  localparam logic [31:0] DIV5_HIGH  = 32'd858993459;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_RAVG   = 7'b0000100,
    S_BAVG   = 7'b0001000,
    S_UDIV   = 7'b0010000,
    S_UAVG   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

### rtl/periodic_task_dispatcher_core.sv
// periodic task dispatcher core
// s_axis carries one request item: set_task, start_cycle, task_done or run_now
// (fields listed beside s_axis_tdata). m_axis carries at most one result item
// per request: a dispatch of a slot inside a cycle, the end of a cycle with its
// statistics, or a standalone dispatch.
// budget_us is written through cfg_we / cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. the block
// takes one request at a time; s_axis_tready is high only in idle. run_now
// gives its result in the cycle after the accept. start_cycle scans one slot
// per cycle until it dispatches a due slot; the scan goes on after that slot's
// task_done. when the cycle ends, a shift-subtract divider finds the usage
// quotient (skipped with a zero period), then the usage average is taken
// (divide by 20 through a reciprocal). an in-cycle task_done updates the run
// average and then the busy average before the scan goes on. a standalone
// task_done keeps the block busy while it updates the run average.
// the result is held in an output register until m_axis_tready; no new
// request is taken until it is gone.
// reset clears the slot table (interval, enable, last run, averages) to zero,
// all statistics to zero and budget_us to 1000.
`default_nettype none
module periodic_task_dispatcher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // operation[1:0] task_slot[5:2] task_interval[37:6] task_enable[38]
  // time_now[70:39] run_duration[102:71] standalone_run[103]
  input  wire logic [103:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_kind[1:0] dispatch_slot[5:2] budget_overrun[6] cpu_usage[38:7]
  // overrun_count[70:39] cycle_count[102:71] busy_time_avg[134:103]
  // slot_run_avg[166:135]
  output logic [167:0]     m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import ptd_pkg::*;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW = $clog2(NUM_SLOTS + 1);

  // request fields
  logic [1:0]  in_op;
  logic [3:0]  in_slot;
  logic [31:0] in_int, in_time, in_dur;
  logic        in_en, in_sa;
  assign in_op   = s_axis_tdata[1:0];
  assign in_slot = s_axis_tdata[5:2];
  assign in_int  = s_axis_tdata[37:6];
  assign in_en   = s_axis_tdata[38];
  assign in_time = s_axis_tdata[70:39];
  assign in_dur  = s_axis_tdata[102:71];
  assign in_sa   = s_axis_tdata[103];

  logic [31:0] slot_interval [NUM_SLOTS];
  logic        slot_enabled  [NUM_SLOTS];
  logic [31:0] slot_last_run [NUM_SLOTS];
  logic [31:0] slot_run_avg_q[NUM_SLOTS];

  logic [31:0] budget, cycle_start, period, busy, usage_avg, busy_avg, overruns, cycles;
  logic [PW-1:0] scan_pos;
  logic        cycle_open;
  logic [31:0] now;        // time of the item driving the scan
  logic [31:0] run_avg;    // run average reported with the result
  logic [SW-1:0] done_slot;
  logic        scan_after; // after averages, continue scanning
  logic        overrun_flag;
  state_t      state;

  // shared divider: quotient of a 64-bit dividend by a 32-bit divisor
  logic [63:0] dq;         // dividend shifting into quotient
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  dcnt;
  logic [32:0] rem_sh, rem_sub;
  assign rem_sh  = {rem[31:0], dq[63]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // averages: dividend pre-shifted by 1 (for 10) or 2 (for 20), then divided by 5
  logic [35:0] div_y;
  logic [64:0] div_prod;
  logic [31:0] div_q;
  assign div_y    = (state == S_RAVG) ? dq[36:1] : dq[37:2];
  assign div_prod = 65'(rem) * 65'(DIV5_RECIP);
  assign div_q    = 32'(dq[3:0]) * DIV5_HIGH + dvs;

  // output register
  logic [1:0]  o_kind;
  logic [3:0]  o_slot;
  logic        o_over;
  logic [31:0] o_ravg;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata = {1'b0, o_ravg, busy_avg, cycles, overruns, usage_avg,
                         o_over, o_slot, o_kind};

  logic [SW-1:0] scan_idx;
  logic [31:0]   s_last, s_int;
  logic          s_due;
  assign scan_idx = scan_pos[SW-1:0];
  assign s_last = slot_last_run[scan_idx];
  assign s_int  = slot_interval[scan_idx];
  assign s_due  = slot_enabled[scan_idx] && (((now - s_last) >= s_int) || (now < s_last));

  logic in_slot_ok;
  assign in_slot_ok = {28'd0, in_slot} < 32'(NUM_SLOTS);

  logic [PW-1:0] pos_m1;
  assign pos_m1 = scan_pos - PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      budget <= BUDGET_RESET;
      cycle_start <= '0; period <= '0; busy <= '0;
      usage_avg <= '0; busy_avg <= '0; overruns <= '0; cycles <= '0;
      scan_pos <= '0; cycle_open <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_interval[i] <= '0; slot_enabled[i] <= 1'b0;
        slot_last_run[i] <= '0; slot_run_avg_q[i] <= '0;
      end
    end else begin
      if (cfg_we) budget <= cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            case (in_op)
              2'(OP_SET_TASK): begin
                if (in_slot_ok) begin
                  slot_interval[in_slot[SW-1:0]] <= in_int;
                  slot_enabled[in_slot[SW-1:0]]  <= in_en;
                end
              end
              2'(OP_START): begin
                if (!cycle_open) begin
                  if (cycle_start == '0 || in_time < cycle_start) period <= '0;
                  else period <= in_time - cycle_start;
                  cycle_start <= in_time;
                  cycles <= cycles + 32'd1;
                  busy <= '0;
                  scan_pos <= '0;
                  cycle_open <= 1'b1;
                  now <= in_time;
                  run_avg <= '0;
                  state <= S_SCAN;
                end
              end
              2'(OP_TASK_DONE): begin
                if (in_sa) begin
                  if (in_slot_ok) begin
                    done_slot <= in_slot[SW-1:0];
                    slot_last_run[in_slot[SW-1:0]] <= in_time;
                    scan_after <= 1'b0;
                    dvs <= in_dur;  // hold duration
                    dq <= 64'(slot_run_avg_q[in_slot[SW-1:0]]) * 64'd9 + 64'(in_dur);
                    rem <= '0; dcnt <= '0;
                    state <= S_RAVG;
                  end
                end else if (cycle_open && scan_pos != '0) begin
                  done_slot <= pos_m1[SW-1:0];
                  slot_last_run[pos_m1[SW-1:0]] <= in_time;
                  now <= in_time;
                  busy <= busy + in_dur;
                  scan_after <= 1'b1;
                  dvs <= in_dur;
                  dq <= 64'(slot_run_avg_q[pos_m1[SW-1:0]]) * 64'd9 + 64'(in_dur);
                  rem <= '0; dcnt <= '0;
                  state <= S_RAVG;
                end
              end
              default: begin
                if (in_slot_ok) begin
                  o_kind <= KIND_STANDALONE;
                  o_slot <= in_slot;
                  o_over <= 1'b0;
                  o_ravg <= slot_run_avg_q[in_slot[SW-1:0]];
                  m_axis_tvalid <= 1'b1;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_pos >= PW'(NUM_SLOTS)) begin
            overrun_flag <= 1'b0;
            cycle_open <= 1'b0;
            state <= S_UDIV;
            dq <= 64'(busy) * 64'(USAGE_SCALE);
            dvs <= period; rem <= '0; dcnt <= '0;
          end else if (s_due) begin
            if (busy > budget) begin
              overruns <= overruns + 32'd1;
              scan_pos <= PW'(NUM_SLOTS);
              overrun_flag <= 1'b1;
              cycle_open <= 1'b0;
              dq <= 64'(busy) * 64'(USAGE_SCALE);
              dvs <= period; rem <= '0; dcnt <= '0;
              state <= S_UDIV;
            end else begin
              scan_pos <= scan_pos + PW'(1);
              o_kind <= KIND_DISPATCH;
              o_slot <= 4'(scan_idx);
              o_over <= 1'b0;
              o_ravg <= run_avg;
              m_axis_tvalid <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            scan_pos <= scan_pos + PW'(1);
          end
        end
        S_UDIV: begin
          // usage quotient: restoring division by the period, one bit per cycle
          if (dcnt == '0 && period == '0) begin
            // zero period, usage average unchanged
            o_kind <= KIND_CYCLE_DONE; o_slot <= '0;
            o_over <= overrun_flag; o_ravg <= run_avg;
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end else if (dcnt < 7'd64) begin
            if (!rem_sub[32]) begin
              rem <= rem_sub; dq <= {dq[62:0], 1'b1};
            end else begin
              rem <= rem_sh; dq <= {dq[62:0], 1'b0};
            end
            dcnt <= dcnt + 7'd1;
          end else begin
            // quotient in dq, saturated to 32 bits
            dq <= 64'(usage_avg) * 64'd19 +
                  ((dq[63:32] != '0) ? 64'hFFFF_FFFF : 64'(dq[31:0]));
            dcnt <= '0;
            state <= S_UAVG;
          end
        end
        S_RAVG, S_BAVG, S_UAVG: begin
          // divide by 10 / 20: high part of the shifted dividend folded in,
          // then the low part divided by 5 through the reciprocal
          if (state == S_RAVG && dcnt == '0 && slot_run_avg_q[done_slot] == '0) begin
            dq <= 64'(dvs);  // zero average, as on a first run: the average takes the duration
            dcnt <= 7'd3;
          end else if (dcnt == 7'd0) begin
            rem <= 33'(div_y[31:0]) + 33'(div_y[35:32]);
            dq <= 64'(div_y[35:32]);
            dcnt <= 7'd1;
          end else if (dcnt == 7'd1) begin
            dvs <= 32'(div_prod[64:34]);
            dcnt <= 7'd2;
          end else if (dcnt == 7'd2) begin
            dq <= 64'(div_q);
            dcnt <= 7'd3;
          end else begin
            // division finished, quotient in dq
            unique case (state)
              S_RAVG: begin
                slot_run_avg_q[done_slot] <= dq[31:0];
                run_avg <= dq[31:0];
                if (scan_after) begin
                  dq <= 64'(busy_avg) * 64'd19 + 64'(busy);
                  dcnt <= '0;
                  state <= S_BAVG;
                end else state <= S_IDLE;
              end
              S_BAVG: begin
                busy_avg <= dq[31:0];
                scan_pos <= scan_pos;
                state <= S_SCAN;
              end
              default: begin
                usage_avg <= dq[31:0];
                o_kind <= KIND_CYCLE_DONE; o_slot <= '0;
                o_over <= overrun_flag; o_ravg <= run_avg;
                m_axis_tvalid <= 1'b1;
                state <= S_IDLE;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
